// ----- src/zovsc_pkg.sv -----
// ----------------------------------------------------------------------------
// zovsc_pkg
// Shared types, command codes and sizes of the zero-one vector set engine.
// ----------------------------------------------------------------------------
`default_nettype none
package zovsc_pkg;
  localparam int unsigned MaxWiresDef = 16;
  localparam int unsigned WordBits    = 64;
  localparam int unsigned WordIdxW    = 6;

  typedef enum logic [2:0] {
    CmdClear    = 3'd0,
    CmdInsert   = 3'd1,
    CmdComp     = 3'd2,
    CmdRevComp  = 3'd3,
    CmdPrune    = 3'd4,
    CmdPairChk  = 3'd5,
    CmdAllSort  = 3'd6,
    CmdCount    = 3'd7
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the item
    logic clr;      // zero the word at the walk position
    logic rd;       // issue a read of the current address pair
    logic wr;       // write back the processed pair
    logic step;     // advance the walk
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic bad;      // wire fields rejected
    logic single;   // command touches one word only
    logic last;     // final walk position
  } stat_t;
endpackage
`default_nettype wire

// ----- src/zovsc_if.sv -----
// ----------------------------------------------------------------------------
// zovsc_in_if / zovsc_out_if
// Valid/ready channels carrying command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none
interface zovsc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  lower_wire;
  logic [3:0]  upper_wire;
  logic [15:0] vector_value;
  modport source (output valid, command, lower_wire, upper_wire, vector_value,
                  input ready);
  modport sink   (input valid, command, lower_wire, upper_wire, vector_value,
                  output ready);
endinterface

interface zovsc_out_if;
  logic        valid;
  logic        ready;
  logic        check_passed;
  logic [16:0] member_count;
  logic        wire_error;
  modport source (output valid, check_passed, member_count, wire_error,
                  input ready);
  modport sink   (input valid, check_passed, member_count, wire_error,
                  output ready);
endinterface
`default_nettype wire

// ----- src/zovsc_datapath.sv -----
// ----------------------------------------------------------------------------
// zovsc_datapath
// Bitmap memory, walk counter and the word-pair operators.
// Two words A and B are processed together each pass. For wires that lie
// inside a word, B is unused and A is mapped within itself. For wires that
// index across words, A holds the word with the upper wire set in the
// cross-word part and B its partner with that part swapped.
// ----------------------------------------------------------------------------
`default_nettype none
module zovsc_datapath #(
  parameter int unsigned MaxWires = zovsc_pkg::MaxWiresDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire zovsc_pkg::ctrl_t   ctrl_i,
  output zovsc_pkg::stat_t        stat_o,
  input  wire logic [4:0]         active_wires_i,
  input  wire logic [2:0]         command_i,
  input  wire logic [3:0]         lower_wire_i,
  input  wire logic [3:0]         upper_wire_i,
  input  wire logic [15:0]        vector_value_i,
  output logic                    check_passed_o,
  output logic [16:0]             member_count_o,
  output logic                    wire_error_o
);
  localparam int unsigned WB    = zovsc_pkg::WordBits;
  localparam int unsigned IW    = zovsc_pkg::WordIdxW;
  localparam int unsigned VecW  = (MaxWires > IW) ? MaxWires : IW + 1;
  localparam int unsigned AddrW = VecW - IW;
  localparam int unsigned Words = 1 << AddrW;
  localparam int unsigned CntW  = VecW + 1;

  // captured item
  logic [2:0]  cmd_q;
  logic [3:0]  lo_q, hi_q;
  logic [15:0] vec_q;
  logic [4:0]  n_q;
  logic        bad_q;

  logic [AddrW-1:0] pos_q;
  logic [WB-1:0]    mem [Words];
  logic [WB-1:0]    ra_q, rb_q;
  logic [AddrW-1:0] aa_q, ab_q;
  logic             chk_q;
  logic [CntW-1:0]  cnt_q;
  logic             skip_q;

  // effective width, clamped
  logic [4:0] n_eff;
  always_comb begin
    n_eff = active_wires_i;
    if (active_wires_i == 5'd0) n_eff = 5'd1;
    else if (active_wires_i > 5'(MaxWires)) n_eff = 5'(MaxWires);
  end

  logic bad_now;
  assign bad_now = (command_i >= zovsc_pkg::CmdComp) && (command_i <= zovsc_pkg::CmdPairChk)
                && ((lower_wire_i >= upper_wire_i) || ({1'b0, upper_wire_i} >= n_eff));

  // wires inside the word or across words
  logic lo_in, hi_in;
  assign lo_in = lo_q < 4'(IW);
  assign hi_in = hi_q < 4'(IW);

  logic [AddrW-1:0] m_lo_a, m_hi_a;
  always_comb begin
    m_lo_a = '0; m_hi_a = '0;
    if (!lo_in) m_lo_a[lo_q - 4'(IW)] = 1'b1;
    if (!hi_in) m_hi_a[hi_q - 4'(IW)] = 1'b1;
  end

  // pair mode: both wires across words, or lower in word and upper across
  logic pair_mode;
  assign pair_mode = !hi_in && ((cmd_q == zovsc_pkg::CmdComp)
                  || (cmd_q == zovsc_pkg::CmdRevComp));

  // address of this pass
  logic [AddrW-1:0] addr_a, addr_b;
  always_comb begin
    addr_a = pos_q;
    addr_b = pos_q;
    if (pair_mode) begin
      addr_a = (pos_q & ~m_hi_a) | m_hi_a;   // upper set
      addr_a = lo_in ? addr_a : (addr_a & ~m_lo_a);
      addr_b = (addr_a & ~m_hi_a) | (lo_in ? '0 : m_lo_a);
    end
  end

  // bit masks of vector positions within a word
  function automatic logic [WB-1:0] bitmask(input logic [IW-1:0] b, input logic v);
    logic [WB-1:0] r;
    for (int i = 0; i < WB; i++) r[i] = (((i >> b) & 1) != 0) == v;
    return r;
  endfunction

  // wire bit masks over the vectors held in word A
  logic [WB-1:0] lo1w, lo0w, hi1w, hi0w;
  always_comb begin
    lo1w = lo_in ? bitmask(lo_q[IW-1:0], 1'b1) : {WB{|(aa_q & m_lo_a)}};
    lo0w = ~lo1w;
    hi1w = hi_in ? bitmask(hi_q[IW-1:0], 1'b1) : {WB{|(aa_q & m_hi_a)}};
    hi0w = ~hi1w;
  end

  // within-word shift of the swap: x ^ m1 ^ m2 as bit moves
  logic [5:0] dlo, dhi;
  assign dlo = lo_q[IW-1:0];
  assign dhi = hi_q[IW-1:0];

  logic [WB-1:0] new_a, new_b, sel01, sel10, img;
  logic          wr_b;
  always_comb begin
    new_a = ra_q; new_b = rb_q; wr_b = 1'b0;
    sel01 = lo0w & hi1w;
    sel10 = lo1w & hi0w;
    img   = '0;
    unique case (cmd_q)
      zovsc_pkg::CmdComp, zovsc_pkg::CmdRevComp: begin
        if (hi_in) begin
          if (cmd_q == zovsc_pkg::CmdComp) begin
            // lo 1 / hi 0 members move up by 2^hi-2^lo
            img   = (ra_q & sel10) << ((WB'(1) << dhi) - (WB'(1) << dlo));
            new_a = (ra_q & ~sel10) | img;
          end else begin
            // lo 0 / hi 1 members add an image 2^hi-2^lo lower
            img   = (ra_q & sel01) >> ((WB'(1) << dhi) - (WB'(1) << dlo));
            new_a = ra_q | img;
          end
        end else if (lo_in) begin
          // A has upper 1, B upper 0
          wr_b = 1'b1;
          if (cmd_q == zovsc_pkg::CmdComp) begin
            img   = (rb_q & lo1w) >> (WB'(1) << dlo);
            new_a = ra_q | img;
            new_b = rb_q & ~lo1w;
          end else begin
            img   = (ra_q & lo0w) << (WB'(1) << dlo);
            new_b = rb_q | img;
          end
        end else begin
          // both across: A upper 1 lower 0, B the swap
          wr_b = 1'b1;
          if (cmd_q == zovsc_pkg::CmdComp) begin
            new_a = ra_q | rb_q;
            new_b = '0;
          end else begin
            new_b = rb_q | ra_q;
          end
        end
      end
      zovsc_pkg::CmdPrune:  new_a = ra_q & ~sel10;
      zovsc_pkg::CmdClear:  new_a = '0;
      zovsc_pkg::CmdInsert: begin
        new_a = ra_q;
        new_a[vec_q[IW-1:0] & IW'((1 << n_q) - 1)] = 1'b1;
      end
      default: ;
    endcase
  end

  // insert address
  logic [15:0]      vmask, vins;
  logic [AddrW-1:0] ins_addr;
  always_comb begin
    vmask    = 16'((17'd1 << n_q) - 17'd1);
    vins     = vec_q & vmask;
    ins_addr = AddrW'({{VecW{1'b0}}, vins} >> IW);
  end

  // sortedness of each vector in word A
  logic [WB-1:0] unsorted;
  logic [VecW-1:0] xv, cv;
  always_comb begin
    for (int i = 0; i < WB; i++) begin
      xv = {aa_q, IW'(i)};
      cv = ~xv & VecW'((32'd1 << n_q) - 1);
      unsorted[i] = (cv & (cv + 1'b1)) != '0;
    end
  end

  logic [6:0] pop;
  always_comb begin
    pop = '0;
    for (int i = 0; i < WB; i++) pop = pop + 7'(ra_q[i]);
  end

  // captured item and walk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; bad_q <= 1'b0; cmd_q <= zovsc_pkg::CmdClear;
      lo_q <= '0; hi_q <= '0; vec_q <= '0; n_q <= 5'd1;
      chk_q <= 1'b1; cnt_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        cmd_q <= command_i; lo_q <= lower_wire_i; hi_q <= upper_wire_i;
        vec_q <= vector_value_i; n_q <= n_eff; bad_q <= bad_now;
        pos_q <= '0; chk_q <= 1'b1; cnt_q <= '0;
      end else if (ctrl_i.step) begin
        pos_q <= pos_q + 1'b1;
      end
      if (ctrl_i.wr) begin
        if (cmd_q == zovsc_pkg::CmdPairChk && |(ra_q & sel10)) chk_q <= 1'b0;
        if (cmd_q == zovsc_pkg::CmdAllSort && |(ra_q & unsorted)) chk_q <= 1'b0;
        if (cmd_q == zovsc_pkg::CmdCount) cnt_q <= cnt_q + CntW'(pop);
      end
    end
  end

  // memory: read pair, write pair back; unused pair positions are skipped
  logic skip;
  assign skip = pair_mode && ((pos_q & m_hi_a) == '0 || (!lo_in && (pos_q & m_lo_a) != '0));
  logic rd_addr_sel;
  assign rd_addr_sel = cmd_q == zovsc_pkg::CmdInsert;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      ra_q <= mem[rd_addr_sel ? ins_addr : addr_a];
      rb_q <= mem[addr_b];
      aa_q <= rd_addr_sel ? ins_addr : addr_a;
      ab_q <= addr_b;
    end
    // clearing pass after reset, one word a cycle
    if (ctrl_i.clr) begin
      mem[pos_q] <= '0;
    end else if (ctrl_i.wr && !(pair_mode && skip_q)) begin
      mem[aa_q] <= new_a;
      if (wr_b) mem[ab_q] <= new_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) skip_q <= 1'b0;
    else if (ctrl_i.rd) skip_q <= skip;
  end

  assign stat_o.bad    = bad_q;
  assign stat_o.single = (cmd_q == zovsc_pkg::CmdInsert);
  assign stat_o.last   = &pos_q;

  assign check_passed_o = !bad_q && (cmd_q == zovsc_pkg::CmdPairChk
                       || cmd_q == zovsc_pkg::CmdAllSort) && chk_q;
  assign member_count_o = (!bad_q && cmd_q == zovsc_pkg::CmdCount) ? 17'(cnt_q) : '0;
  assign wire_error_o   = bad_q;
endmodule
`default_nettype wire

// ----- src/zovsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// zovsc_ctrl
// Sequencer: clearing pass, capture, read/write walk over the bitmap,
// result beat.
// ----------------------------------------------------------------------------
`default_nettype none
module zovsc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire zovsc_pkg::stat_t stat_i,
  output zovsc_pkg::ctrl_t      ctrl_o
);
  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SChk  = 3'd1;
  localparam logic [2:0] SRd   = 3'd2;
  localparam logic [2:0] SWr   = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;
  localparam logic [2:0] SInit = 3'd5;

  logic [2:0] state_q, state_d;
  logic       last_q, last_d;

  always_comb begin
    state_d = state_q;
    last_d  = last_q;
    ctrl_o  = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      SInit: begin
        ctrl_o.clr  = 1'b1;
        ctrl_o.step = 1'b1;
        if (stat_i.last) state_d = SIdle;
      end
      SIdle: begin
        in_ready_o  = 1'b1;
        ctrl_o.load = in_valid_i;
        if (in_valid_i) state_d = SChk;
      end
      SChk: begin
        last_d = stat_i.single;
        state_d = stat_i.bad ? SOut : SRd;
      end
      SRd: begin
        ctrl_o.rd = 1'b1;
        last_d = last_q | stat_i.last;
        ctrl_o.step = 1'b1;
        state_d = SWr;
      end
      SWr: begin
        ctrl_o.wr = 1'b1;
        state_d = last_q ? SOut : SRd;
      end
      SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      last_q  <= last_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut && !out_ready_i) |=> state_q == SOut)
    else $error("result beat dropped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.wr |-> $past(ctrl_o.rd))
    else $error("write without read");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("accept while result pending");
endmodule
`default_nettype wire

// ----- src/zero_one_vector_set_comparator_engine.sv -----
// ----------------------------------------------------------------------------
// zero_one_vector_set_comparator_engine
// Membership bitmap over binary vectors with comparator operations.
//
//  channel | dir | beat contents
//  in_ch   | in  | command, lower_wire, upper_wire, vector_value
//  out_ch  | out | check_passed, member_count, wire_error
//  cfg     | in  | active_wires (write enable + data)
//
// A set-wide command walks all 2^(MaxWires-6) words, with a read step and a
// write step for each. Insert visits only the word that it sets, and a
// rejected command goes from the check state straight to the result beat.
// After reset a clearing pass zeroes one word a cycle, with the input held
// off. Output stall holds the block in its result state.
// ----------------------------------------------------------------------------
`default_nettype none
module zero_one_vector_set_comparator_engine #(
  parameter int unsigned MaxWires = zovsc_pkg::MaxWiresDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [4:0] cfg_wdata_i,
  zovsc_in_if.sink        in_ch,
  zovsc_out_if.source     out_ch
);
  logic [4:0] active_wires_q;
  zovsc_pkg::ctrl_t ctrl;
  zovsc_pkg::stat_t stat;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_wires_q <= 5'd16;
    else if (cfg_we_i) active_wires_q <= cfg_wdata_i;
  end

  zovsc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_ch.valid), .in_ready_o (in_ch.ready),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .stat_i (stat), .ctrl_o (ctrl)
  );

  zovsc_datapath #(.MaxWires(MaxWires)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i (ctrl), .stat_o (stat),
    .active_wires_i (active_wires_q),
    .command_i (in_ch.command), .lower_wire_i (in_ch.lower_wire),
    .upper_wire_i (in_ch.upper_wire), .vector_value_i (in_ch.vector_value),
    .check_passed_o (out_ch.check_passed), .member_count_o (out_ch.member_count),
    .wire_error_o (out_ch.wire_error)
  );
endmodule
`default_nettype wire

// ----- tb/sv/zero_one_vector_set_comparator_engine_tb.sv -----
// ----------------------------------------------------------------------------
// zero_one_vector_set_comparator_engine_tb
// Self-checking bench: command beats come from a queue through a bursty
// driver. A local bitmap model predicts each result beat, and a monitor
// compares the result beats against it while the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module zero_one_vector_set_comparator_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SetSize   = 1 << zovsc_pkg::MaxWiresDef;
  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned LongHold  = 3000;

  typedef struct packed {
    zovsc_pkg::cmd_e command;
    logic [3:0]      lower_wire;
    logic [3:0]      upper_wire;
    logic [15:0]     vector_value;
  } cmd_beat_t;

  typedef struct packed {
    logic        check_passed;
    logic [16:0] member_count;
    logic        wire_error;
  } res_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;

  zovsc_in_if  in_ch ();
  zovsc_out_if out_ch ();

  zero_one_vector_set_comparator_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  always #5ns clk_i = ~clk_i;

  // model state
  bit          membership [SetSize];
  int unsigned set_width = zovsc_pkg::MaxWiresDef;

  cmd_beat_t pending_cmds [$];
  res_beat_t expected_results [$];
  int unsigned errors = 0;
  bit          in_fire = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned idle_cycles = 0;

  // Apply one command to the local bitmap and return its result beat
  function automatic res_beat_t apply_command(cmd_beat_t c);
    res_beat_t   r;
    int unsigned lo, hi, x, y, n, cnt;
    logic [16:0] wmask, cz;
    r = '0;
    lo = c.lower_wire;
    hi = c.upper_wire;
    n = set_width;
    wmask = (17'd1 << n) - 17'd1;
    if (c.command inside {zovsc_pkg::CmdComp, zovsc_pkg::CmdRevComp,
                          zovsc_pkg::CmdPrune, zovsc_pkg::CmdPairChk} &&
        (lo >= hi || hi >= n)) begin
      r.wire_error = 1'b1;
      return r;
    end
    case (c.command)
      zovsc_pkg::CmdClear: begin
        for (x = 0; x < SetSize; x++) membership[x] = 1'b0;
      end
      zovsc_pkg::CmdInsert: membership[c.vector_value & wmask[15:0]] = 1'b1;
      zovsc_pkg::CmdComp: begin
        for (x = 0; x < SetSize; x++)
          if (!x[lo] && x[hi]) begin
            y = x ^ (1 << lo) ^ (1 << hi);
            membership[x] = membership[x] | membership[y];
            membership[y] = 1'b0;
          end
      end
      zovsc_pkg::CmdRevComp: begin
        for (x = 0; x < SetSize; x++)
          if (!x[lo] && x[hi] && membership[x])
            membership[x ^ (1 << lo) ^ (1 << hi)] = 1'b1;
      end
      zovsc_pkg::CmdPrune: begin
        for (x = 0; x < SetSize; x++)
          if (x[lo] && !x[hi]) membership[x] = 1'b0;
      end
      zovsc_pkg::CmdPairChk: begin
        r.check_passed = 1'b1;
        for (x = 0; x < SetSize; x++)
          if (x[lo] && !x[hi] && membership[x]) r.check_passed = 1'b0;
      end
      zovsc_pkg::CmdAllSort: begin
        r.check_passed = 1'b1;
        for (x = 0; x < SetSize; x++)
          if (membership[x]) begin
            cz = ~x[16:0] & wmask;
            if ((cz & (cz + 17'd1)) != 0) r.check_passed = 1'b0;
          end
      end
      default: begin
        cnt = 0;
        for (x = 0; x < SetSize; x++) cnt += membership[x];
        r.member_count = cnt[16:0];
      end
    endcase
    return r;
  endfunction

  // Sampling side: prediction on accepted command beats, checks on results
  always @(posedge clk_i) begin
    res_beat_t got, want;
    in_fire = in_ch.valid && in_ch.ready;
    if (in_fire)
      expected_results.push_back(apply_command({zovsc_pkg::cmd_e'(in_ch.command),
          in_ch.lower_wire, in_ch.upper_wire, in_ch.vector_value}));
    if (out_ch.valid && out_ch.ready) begin
      got = {out_ch.check_passed, out_ch.member_count, out_ch.wire_error};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.check_passed !== want.check_passed) begin
          $display("%0t: check_passed exp %b got %b", $time,
                   want.check_passed, got.check_passed);
          errors++;
        end
        if (got.member_count !== want.member_count) begin
          $display("%0t: member_count exp %0d got %0d", $time,
                   want.member_count, got.member_count);
          errors++;
        end
        if (got.wire_error !== want.wire_error) begin
          $display("%0t: wire_error exp %b got %b", $time,
                   want.wire_error, got.wire_error);
          errors++;
        end
      end
    end
    // watchdog on beats of either channel
    if (in_fire || (out_ch.valid && out_ch.ready) || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Driver: bursts of beats with random gaps in between
  int unsigned gap_left = 0, burst_left = 4;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = '0;
    in_ch.lower_wire = '0;
    in_ch.upper_wire = '0;
    in_ch.vector_value = '0;
  end
  always @(negedge clk_i) begin
    cmd_beat_t c;
    if (rst_ni && (!in_ch.valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        c = pending_cmds.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= c.command;
        in_ch.lower_wire <= c.lower_wire;
        in_ch.upper_wire <= c.upper_wire;
        in_ch.vector_value <= c.vector_value;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: free-flow and random stall stretches in random order, one long hold
  int unsigned hold_left = 0, mode_left = 0;
  bit          hold_done = 1'b0, stall_mode = 1'b0;
  initial out_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      mode_left = $urandom_range(50, 400);
      stall_mode = $urandom_range(0, 1);
    end else mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (long_hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LongHold;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !stall_mode || ($urandom_range(0, 3) == 0);
    end
  end

  // Wait until the block has drained everything queued so far
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_width(logic [4:0] w);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    set_width = (w < 1) ? 1 : (w > zovsc_pkg::MaxWiresDef) ? zovsc_pkg::MaxWiresDef : w;
  endtask

  task automatic push_cmd(zovsc_pkg::cmd_e c, int unsigned lo, int unsigned hi,
                          int unsigned v);
    pending_cmds.push_back({c, lo[3:0], hi[3:0], v[15:0]});
  endtask

  // Random commands: mostly legal wire pairs, some noise on the fields
  task automatic push_random(int unsigned count);
    int unsigned     lo, hi, k;
    zovsc_pkg::cmd_e c;
    for (k = 0; k < count; k++) begin
      c = zovsc_pkg::cmd_e'($urandom_range(0, 7));
      if ($urandom_range(0, 9) < 4) c = zovsc_pkg::CmdInsert;
      if (c == zovsc_pkg::CmdClear && $urandom_range(0, 3) != 0) c = zovsc_pkg::CmdInsert;
      if ($urandom_range(0, 6) == 0 || set_width < 2) begin
        lo = $urandom_range(0, 15);
        hi = $urandom_range(0, 15);
      end else begin
        lo = $urandom_range(0, set_width - 2);
        hi = $urandom_range(lo + 1, set_width - 1);
      end
      push_cmd(c, lo, hi, $urandom_range(0, 16'hFFFF));
    end
  endtask

  initial begin
    logic [4:0] widths [6] = '{5'd1, 5'd0, 5'd31, 5'd4, 5'd8, 5'd5};
    int unsigned p;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty set out of reset, then a few members
    push_cmd(zovsc_pkg::CmdCount, 0, 0, 0);
    push_cmd(zovsc_pkg::CmdAllSort, 0, 0, 0);
    push_cmd(zovsc_pkg::CmdClear, 0, 0, 0);
    push_cmd(zovsc_pkg::CmdPairChk, 0, 15, 0);
    push_cmd(zovsc_pkg::CmdInsert, 0, 0, 16'h0000);
    push_cmd(zovsc_pkg::CmdInsert, 0, 0, 16'hFFFF);
    push_cmd(zovsc_pkg::CmdInsert, 0, 0, 16'h00F0);
    push_cmd(zovsc_pkg::CmdInsert, 0, 0, 16'h8001);
    push_cmd(zovsc_pkg::CmdCount, 0, 0, 0);
    push_cmd(zovsc_pkg::CmdAllSort, 0, 0, 0);
    push_cmd(zovsc_pkg::CmdPairChk, 0, 15, 0);
    push_cmd(zovsc_pkg::CmdComp, 5, 5, 0);      // equal wires
    push_cmd(zovsc_pkg::CmdRevComp, 9, 3, 0);   // lower above upper
    push_cmd(zovsc_pkg::CmdPrune, 15, 0, 0);
    push_cmd(zovsc_pkg::CmdPairChk, 7, 7, 0);
    push_cmd(zovsc_pkg::CmdRevComp, 0, 15, 0);
    push_cmd(zovsc_pkg::CmdCount, 0, 0, 0);
    push_cmd(zovsc_pkg::CmdComp, 0, 15, 0);
    push_cmd(zovsc_pkg::CmdPairChk, 0, 15, 0);
    push_cmd(zovsc_pkg::CmdPrune, 4, 7, 0);
    push_cmd(zovsc_pkg::CmdCount, 0, 0, 0);
    push_random(40);
    long_hold_req = 1'b1;
    wait_drained();

    // narrower widths, clamped values, members kept across changes
    for (p = 0; p < 6; p++) begin
      write_width(widths[p]);
      if (p == 3) push_cmd(zovsc_pkg::CmdComp, 2, 7, 0); // upper beyond width
      push_random(40);
    end
    write_width(5'd16);
    push_random(10);
    wait_drained();

    repeat (2200) @(posedge clk_i);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
